// ===== rtl/sis_pkg.sv =====
package sis_pkg;

    // Number of cells in the sorting row (supported range 2 to 64).
    localparam int unsigned DEPTH = 64;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned TAG_W = 32;

    // One stored record.
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic signed [TAG_W-1:0] payload;
    } rec_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                    insert;  // place new record, shift greater ones up
        logic                    drain;   // shift whole row down by one
        logic signed [KEY_W-1:0] key;
        logic signed [TAG_W-1:0] payload;
    } cell_ctl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } sis_state_t;

endpackage

// ===== rtl/stable_insertion_sorter.sv =====
// Stable insertion sorter. Records (signed key, payload tag) enter on the s_
// channel at one transfer per clock while collecting. Each lands in a row of
// DEPTH cells that compare against the arriving key in parallel: every cell
// holding a strictly greater key (or empty) shifts up one place, so a new
// record goes after all stored records of equal key. The record flagged by
// s_final_item is inserted as well; the block then stops accepting input and
// drains the row from the low end, one result per cycle unless m_ready stalls,
// via an output register, in ascending key order, m_run_end high on the last one.
// m_overflowed is high on every result of a run in which a record arrived
// while all DEPTH cells were full; such records are discarded. After the last
// result has been loaded into the output register, input is accepted again.
module stable_insertion_sorter import sis_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [KEY_W-1:0] s_sort_key,
    input  logic signed [TAG_W-1:0] s_payload,
    input  logic                    s_final_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [KEY_W-1:0] m_out_key,
    output logic signed [TAG_W-1:0] m_out_payload,
    output logic                    m_run_end,
    output logic                    m_overflowed
);

    sis_state_t state_reg;
    sis_state_t state_next;
    logic       drop_flag_reg;
    logic       drop_flag_next;

    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic signed [KEY_W-1:0] m_key_reg;
    logic signed [TAG_W-1:0] m_tag_reg;
    logic                    m_end_reg;
    logic                    m_ovf_reg;

    cell_ctl_t        ctl;
    rec_t             row_rec [DEPTH];
    logic [DEPTH-1:0] row_gt;
    logic [DEPTH-1:0] row_valid;

    logic s_xfer;
    logic full;
    logic out_free;
    logic drain;
    logic drain_last;

    // ---------------------------------------------------------------------
    // Cell row: cell 0 holds the smallest key.
    // ---------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_row
            rec_t left_rec;
            logic left_gt;
            rec_t right_rec;

            if (gi == 0) begin : g_first
                assign left_rec = '0;
                assign left_gt  = 1'b0;
            end else begin : g_mid
                assign left_rec = row_rec[gi-1];
                assign left_gt  = row_gt[gi-1];
            end

            if (gi == DEPTH-1) begin : g_last
                assign right_rec = '0;
            end else begin : g_inner
                assign right_rec = row_rec[gi+1];
            end

            sis_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .left_rec  (left_rec),
                .left_gt   (left_gt),
                .right_rec (right_rec),
                .rec       (row_rec[gi]),
                .gt        (row_gt[gi])
            );

            assign row_valid[gi] = row_rec[gi].valid;
        end
    endgenerate

    // ---------------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------------
    assign full     = row_valid[DEPTH-1];
    assign s_ready  = (state_reg == ST_COLLECT);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    // Valid cells always form a prefix, so the run ends when cell 1 is empty.
    assign drain      = (state_reg == ST_DRAIN) && out_free && row_valid[0];
    assign drain_last = drain && !row_valid[1];

    assign ctl.insert  = s_xfer && !full;
    assign ctl.drain   = drain;
    assign ctl.key     = s_sort_key;
    assign ctl.payload = s_payload;

    always_comb begin
        state_next     = state_reg;
        drop_flag_next = drop_flag_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (s_xfer) begin
                    if (full) begin
                        drop_flag_next = 1'b1;
                    end
                    if (s_final_item) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (drain_last) begin
                    state_next     = ST_COLLECT;
                    drop_flag_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_COLLECT;
            drop_flag_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            drop_flag_reg <= drop_flag_next;
        end
    end

    // ---------------------------------------------------------------------
    // Output register: decouples the row from m_ready back-pressure.
    // ---------------------------------------------------------------------
    always_comb begin
        if (drain) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            m_key_reg <= row_rec[0].key;
            m_tag_reg <= row_rec[0].payload;
            m_end_reg <= drain_last;
            m_ovf_reg <= drop_flag_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_key     = m_key_reg;
    assign m_out_payload = m_tag_reg;
    assign m_run_end     = m_end_reg;
    assign m_overflowed  = m_ovf_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_valid & (row_valid + 1'b1)) == '0)
        else $error("occupied cells do not form a prefix");

    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> row_valid[0])
        else $error("drain state with empty row");

    a_empty_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_last |=> (row_valid == '0) && !drop_flag_reg)
        else $error("row not empty after last result");

    a_drop_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && full && !s_final_item) |=> drop_flag_reg)
        else $error("dropped record not flagged");

    a_no_insert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && full) |=> (row_valid == $past(row_valid)))
        else $error("row changed on dropped record");

endmodule

// ===== rtl/sis_cell.sv =====
module sis_cell import sis_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  rec_t      left_rec,   // neighbor one place lower in the order
    input  logic      left_gt,
    input  rec_t      right_rec,  // neighbor one place higher in the order
    output rec_t      rec,
    output logic      gt
);

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic signed [TAG_W-1:0] tag_reg;
    logic signed [TAG_W-1:0] tag_next;

    // Empty cell acts as +infinity; equal keys stay put (stable order).
    assign gt = !valid_reg || ($signed(key_reg) > $signed(ctl.key));

    assign rec.valid   = valid_reg;
    assign rec.key     = key_reg;
    assign rec.payload = tag_reg;

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        if (ctl.drain) begin
            valid_next = right_rec.valid;
            key_next   = right_rec.key;
            tag_next   = right_rec.payload;
        end else if (ctl.insert && gt) begin
            if (left_gt) begin
                valid_next = left_rec.valid;
                key_next   = left_rec.key;
                tag_next   = left_rec.payload;
            end else begin
                valid_next = 1'b1;
                key_next   = ctl.key;
                tag_next   = ctl.payload;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule
